FILE: rtl/sdma_pkg.sv
// ---------------------------------------------------------------------------
// sdma_pkg: shared types and codes for the sprite DMA sequencer
// Request codes, bus action codes, transfer constants and the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

package sdma_pkg;

   // request codes
   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_CPU_READ = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;

   // bus action codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_DUMMY = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   // transfer bookkeeping
   localparam int          COUNT_WIDTH    = 10;
   localparam logic [9:0]  TRANSFER_TOTAL = 10'h200;
   localparam logic [15:0] PORT_A         = 16'h4016;
   localparam logic [15:0] PORT_B         = 16'h4017;

   // one result beat
   typedef struct packed {
      logic [1:0]  bus_op;
      logic [15:0] bus_address;
      logic [7:0]  oam_data;
      logic        busy_res;
      logic        cpu_proceed;
   } sdma_result_type;

endpackage

`default_nettype wire

FILE: rtl/sdma_engine.sv
// ---------------------------------------------------------------------------
// sdma_engine: sequencer state and per-cycle bus action decode
// Holds the DMA state and works out one bus action for each accepted beat.
// ---------------------------------------------------------------------------
`default_nettype none

module sdma_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [1:0]               req_type,
   input  wire logic [7:0]               page,
   input  wire logic [15:0]              cpu_address,
   input  wire logic [7:0]               bus_data,
   output sdma_pkg::sdma_result_type     result
);

   logic                                  halt_pending_ff, halt_pending_in;
   logic                                  sprite_active_ff, sprite_active_in;
   logic [7:0]                            source_page_ff, source_page_in;
   logic [7:0]                            read_offset_ff, read_offset_in;
   logic [sdma_pkg::COUNT_WIDTH-1:0]      transfer_count_ff, transfer_count_in;
   logic [sdma_pkg::COUNT_WIDTH-1:0]      count_inc;
   logic                                  cycle_odd_ff, cycle_odd_in;
   logic                                  skip_dummy_ff, skip_dummy_in;
   logic [15:0]                           halted_address_ff, halted_address_in;
   logic [7:0]                            data_latch_ff, data_latch_in;
   logic [1:0]                            op;
   logic [15:0]                           addr;
   logic                                  proceed;

   assign count_inc = transfer_count_ff + 1'b1;

   // decode this cycle's bus action and next state
   always_comb begin
      halt_pending_in   = halt_pending_ff;
      sprite_active_in  = sprite_active_ff;
      source_page_in    = source_page_ff;
      read_offset_in    = read_offset_ff;
      transfer_count_in = transfer_count_ff;
      skip_dummy_in     = skip_dummy_ff;
      halted_address_in = halted_address_ff;
      data_latch_in     = data_latch_ff;
      op                = sdma_pkg::OP_NONE;
      addr              = 16'h0000;
      proceed           = 1'b0;
      if (req_type == sdma_pkg::REQ_START) begin
         halt_pending_in  = 1'b1;
         sprite_active_in = 1'b1;
         source_page_in   = page;
      end else if (req_type == sdma_pkg::REQ_CPU_READ && halt_pending_ff) begin
         // take over the CPU read as the halt cycle
         op                = sdma_pkg::OP_DUMMY;
         addr              = cpu_address;
         halted_address_in = cpu_address;
         skip_dummy_in     = (cpu_address == sdma_pkg::PORT_A) ||
                             (cpu_address == sdma_pkg::PORT_B);
         halt_pending_in   = 1'b0;
         read_offset_in    = 8'h00;
         transfer_count_in = '0;
      end else if (sprite_active_ff && !halt_pending_ff) begin
         if (cycle_odd_ff) begin
            op                = sdma_pkg::OP_READ;
            addr              = {source_page_ff, read_offset_ff};
            read_offset_in    = read_offset_ff + 8'h01;
            transfer_count_in = count_inc;
         end else if (transfer_count_ff[0]) begin
            op                = sdma_pkg::OP_WRITE;
            data_latch_in     = bus_data;
            transfer_count_in = count_inc;
            if (count_inc == sdma_pkg::TRANSFER_TOTAL) begin
               sprite_active_in = 1'b0;
               proceed          = 1'b1;
            end
         end else if (!skip_dummy_ff) begin
            // alignment dummy read
            op   = sdma_pkg::OP_DUMMY;
            addr = halted_address_ff;
         end
      end else if (req_type == sdma_pkg::REQ_CPU_READ && !sprite_active_ff) begin
         proceed = 1'b1;
      end
      cycle_odd_in = ~cycle_odd_ff;
   end

   // assemble the result beat
   always_comb begin
      result.bus_op      = op;
      result.bus_address = addr;
      result.oam_data    = (op == sdma_pkg::OP_WRITE) ? data_latch_in : 8'h00;
      result.busy_res    = sprite_active_in | halt_pending_in;
      result.cpu_proceed = proceed;
   end

   // advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_pending_ff   <= 1'b0;
         sprite_active_ff  <= 1'b0;
         source_page_ff    <= 8'h00;
         read_offset_ff    <= 8'h00;
         transfer_count_ff <= '0;
         cycle_odd_ff      <= 1'b0;
         skip_dummy_ff     <= 1'b0;
         halted_address_ff <= 16'h0000;
         data_latch_ff     <= 8'h00;
      end else if (accept) begin
         halt_pending_ff   <= halt_pending_in;
         sprite_active_ff  <= sprite_active_in;
         source_page_ff    <= source_page_in;
         read_offset_ff    <= read_offset_in;
         transfer_count_ff <= transfer_count_in;
         cycle_odd_ff      <= cycle_odd_in;
         skip_dummy_ff     <= skip_dummy_in;
         halted_address_ff <= halted_address_in;
         data_latch_ff     <= data_latch_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sdma_rsp_buf.sv
// ---------------------------------------------------------------------------
// sdma_rsp_buf: result register with skid stage
// Registers each result beat and parks one extra beat while the sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module sdma_rsp_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire sdma_pkg::sdma_result_type in_data,
   output logic                          in_stall,
   output logic                          out_valid,
   output sdma_pkg::sdma_result_type     out_data,
   input  wire logic                     out_stall
);

   logic                       out_valid_ff;
   logic                       skid_valid_ff;
   sdma_pkg::sdma_result_type  out_data_ff;
   sdma_pkg::sdma_result_type  skid_data_ff;
   logic                       accept;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid & ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // control: refill the output register or park the beat in the skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || !out_stall) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (accept) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sprite_dma_sequencer_top.sv
// ---------------------------------------------------------------------------
// sprite_dma_sequencer_top: sprite memory DMA sequencer
// One request beat per CPU bus cycle in, one bus action beat out.
// ---------------------------------------------------------------------------
// Each request beat stands for one CPU bus cycle and produces exactly one
// response beat that names the bus action for that cycle. A start beat
// latches the source page; the next CPU read becomes the halt cycle, after
// which reads and sprite memory writes alternate by cycle parity until the
// count reaches 512 (256 reads, 256 writes). Throughput is one beat per
// clock while the skid is empty: the step logic is a single combinational
// pass from the state registers to the response register, and a two-entry
// output buffer (response register plus skid) parks one beat while the
// response side stalls; requests stall while the skid is full.
`default_nettype none

module sprite_dma_sequencer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_page,
   input  wire logic [15:0] req_cpu_address,
   input  wire logic [7:0]  req_bus_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_bus_op,
   output logic [15:0]      rsp_bus_address,
   output logic [7:0]       rsp_oam_data,
   output logic             rsp_busy_res,
   output logic             rsp_cpu_proceed
);

   sdma_pkg::sdma_result_type step_result;
   sdma_pkg::sdma_result_type rsp_result;
   logic                      accept;

   assign accept = req_valid & ~req_stall;

   // sequencer state and step logic
   sdma_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_type),
      .page        (req_page),
      .cpu_address (req_cpu_address),
      .bus_data    (req_bus_data),
      .result      (step_result)
   );

   // response register and skid
   sdma_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (step_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_result),
      .out_stall (rsp_stall)
   );

   assign rsp_bus_op      = rsp_result.bus_op;
   assign rsp_bus_address = rsp_result.bus_address;
   assign rsp_oam_data    = rsp_result.oam_data;
   assign rsp_busy_res    = rsp_result.busy_res;
   assign rsp_cpu_proceed = rsp_result.cpu_proceed;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for sprite_dma_sequencer_top
// Drives request beats through the valid/stall handshake with random gaps
// and response stalls. Every accepted request is run through a cycle-exact
// predictor of the sprite DMA engine. Each response beat is compared field
// by field with the oldest predicted bus action.
// ---------------------------------------------------------------------------

module tb;

   // unused request code, handled by the block as a tick
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam int ITEM_TARGET    = 1150;
   localparam int STEADY_FROM    = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type        = sdma_pkg::REQ_TICK;
   logic [7:0]  req_page        = 8'h00;
   logic [15:0] req_cpu_address = 16'h0000;
   logic [7:0]  req_bus_data    = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_bus_op;
   logic [15:0] rsp_bus_address;
   logic [7:0]  rsp_oam_data;
   logic        rsp_busy_res;
   logic        rsp_cpu_proceed;

   // predicted DMA engine state
   logic        halt_armed  = 1'b0;
   logic        dma_running = 1'b0;
   logic        odd_cycle   = 1'b0;
   logic        no_dummy    = 1'b0;
   logic [7:0]  src_page    = 8'h00;
   logic [7:0]  next_offset = 8'h00;
   logic [9:0]  xfer_count  = 10'd0;
   logic [15:0] halt_addr   = 16'h0000;

   sdma_pkg::sdma_result_type pending_actions[$];
   sdma_pkg::sdma_result_type want;

   int          work_items   = 0;
   int          mismatches   = 0;
   int          idle_cycles  = 0;
   int          stall_left   = 0;
   bit          req_gappy    = 1'b1;
   bit          rsp_gappy    = 1'b1;
   bit          steady_tail  = 1'b0;

   sprite_dma_sequencer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_page        (req_page),
      .req_cpu_address (req_cpu_address),
      .req_bus_data    (req_bus_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bus_op      (rsp_bus_op),
      .rsp_bus_address (rsp_bus_address),
      .rsp_oam_data    (rsp_oam_data),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_cpu_proceed (rsp_cpu_proceed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the engine by one bus cycle and return the action it issues.
   function automatic sdma_pkg::sdma_result_type predict_bus_action(
         input logic [1:0] kind, input logic [7:0] page,
         input logic [15:0] addr, input logic [7:0] data);
      sdma_pkg::sdma_result_type beat;
      beat = '0;
      if (kind == sdma_pkg::REQ_START) begin
         halt_armed  = 1'b1;
         dma_running = 1'b1;
         src_page    = page;
      end else if (kind == sdma_pkg::REQ_CPU_READ && halt_armed) begin
         // take over the CPU read as the halt cycle
         beat.bus_op      = sdma_pkg::OP_DUMMY;
         beat.bus_address = addr;
         halt_addr        = addr;
         no_dummy         = (addr == sdma_pkg::PORT_A || addr == sdma_pkg::PORT_B);
         halt_armed       = 1'b0;
         next_offset      = 8'h00;
         xfer_count       = '0;
      end else if (dma_running && !halt_armed) begin
         if (odd_cycle) begin
            beat.bus_op      = sdma_pkg::OP_READ;
            beat.bus_address = {src_page, next_offset};
            next_offset      = next_offset + 8'd1;
            xfer_count       = xfer_count + 10'd1;
         end else if (xfer_count[0]) begin
            beat.bus_op   = sdma_pkg::OP_WRITE;
            beat.oam_data = data;
            xfer_count    = xfer_count + 10'd1;
            if (xfer_count == sdma_pkg::TRANSFER_TOTAL) begin
               dma_running      = 1'b0;
               beat.cpu_proceed = 1'b1;
            end
         end else if (!no_dummy) begin
            // alignment cycle, silent for the controller ports
            beat.bus_op      = sdma_pkg::OP_DUMMY;
            beat.bus_address = halt_addr;
         end
      end else if (kind == sdma_pkg::REQ_CPU_READ && !dma_running) begin
         beat.cpu_proceed = 1'b1;
      end
      odd_cycle     = ~odd_cycle;
      beat.busy_res = dma_running || halt_armed;
      return beat;
   endfunction

   // Pick a CPU address, weighted toward the controller ports and the ends.
   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 7))
         0:       return sdma_pkg::PORT_A;
         1:       return sdma_pkg::PORT_B;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Send one request beat, with an optional gap in front, and record its action.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] page,
                            input logic [15:0] addr, input logic [7:0] data);
      int unsigned gap;
      bit          ignored;
      gap = 0;
      if (req_gappy && !steady_tail && $urandom_range(0, 9) == 0)
         gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_page        <= page;
      req_cpu_address <= addr;
      req_bus_data    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // idle ticks do not count as work
      ignored = !(dma_running || halt_armed) &&
                (kind == sdma_pkg::REQ_TICK || kind == REQ_SPARE);
      if (!ignored)
         work_items++;
      if (work_items >= STEADY_FROM)
         steady_tail = 1'b1;
      pending_actions.push_back(predict_bus_action(kind, page, addr, data));
   endtask

   // Hold off the sender until every predicted action has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_actions.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_and_extremes();
      // idle CPU reads proceed, idle ticks do nothing
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_TICK, 8'hFF, 16'hFFFF, 8'hFF);
      send_beat(REQ_SPARE, 8'h00, 16'h0000, 8'h00);
      // armed: ticks issue nothing, halt on the controller port
      send_beat(sdma_pkg::REQ_START, 8'hFF, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h1234, 8'h00);
      send_beat(REQ_SPARE, 8'h00, 16'h1234, 8'h00);
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, sdma_pkg::PORT_A, 8'h00);
      send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'hFF);
      send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'hFF);
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, 16'hFFFF, 8'h00);
      send_beat(REQ_SPARE, 8'h00, 16'h0000, 8'hA5);
      // restart while running, halt at the top address
      send_beat(sdma_pkg::REQ_START, 8'h00, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, 16'hFFFF, 8'h00);
      repeat (4) send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h5A);
      // restart again, halt on the other controller port
      send_beat(sdma_pkg::REQ_START, 8'h80, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, sdma_pkg::PORT_B, 8'h00);
      repeat (3) send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'hFF);
   endtask

   task automatic test_drain_pause();
      send_beat(sdma_pkg::REQ_START, 8'h5A, 16'h0000, 8'h00);
      send_beat(sdma_pkg::REQ_CPU_READ, 8'h00, 16'h2002, 8'h00);
      repeat (4) send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'($urandom));
      wait_drain();
      repeat (4) send_beat(sdma_pkg::REQ_TICK, 8'h00, 16'h0000, 8'($urandom));
      wait_drain();
   endtask

   task automatic test_random_runs();
      int unsigned pick;
      logic [1:0]  kind;
      while (work_items < ITEM_TARGET) begin
         req_gappy = $urandom_range(0, 2) != 0;
         rsp_gappy = $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 2) == 0) begin
            // noise: any request with any content
            repeat ($urandom_range(2, 10))
               send_beat(2'($urandom), 8'($urandom), pick_address(), 8'($urandom));
         end else begin
            // well-formed transfer: start, a few ticks, halt, then run to the end
            case ($urandom_range(0, 3))
               0:       send_beat(sdma_pkg::REQ_START, 8'h00, 16'($urandom),
                                  8'($urandom));
               1:       send_beat(sdma_pkg::REQ_START, 8'hFF, 16'($urandom),
                                  8'($urandom));
               default: send_beat(sdma_pkg::REQ_START, 8'($urandom), 16'($urandom),
                                  8'($urandom));
            endcase
            repeat ($urandom_range(0, 3))
               send_beat($urandom_range(0, 1) ? sdma_pkg::REQ_TICK : REQ_SPARE,
                         8'($urandom), 16'($urandom), 8'($urandom));
            send_beat(sdma_pkg::REQ_CPU_READ, 8'($urandom), pick_address(),
                      8'($urandom));
            while ((dma_running || halt_armed) && work_items < ITEM_TARGET) begin
               pick = $urandom_range(0, 299);
               if (pick == 0)
                  kind = sdma_pkg::REQ_START;
               else if (pick < 110)
                  kind = sdma_pkg::REQ_CPU_READ;
               else if (pick < 260)
                  kind = sdma_pkg::REQ_TICK;
               else
                  kind = REQ_SPARE;
               send_beat(kind, 8'($urandom), pick_address(), 8'($urandom));
               if (!steady_tail && $urandom_range(0, 199) == 0)
                  wait_drain();
            end
         end
         if (!steady_tail && $urandom_range(0, 3) == 0)
            wait_drain();
      end
   endtask

   // Stall the response side in random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_gappy && !steady_tail && $urandom_range(0, 11) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_field(input string what, input int unsigned expv,
                               input int unsigned actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, expv, actv);
         mismatches++;
      end
   endtask

   // Check each accepted response beat against the oldest predicted action.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_actions.size() == 0) begin
            $display("%0t: response beat with nothing predicted, expected none actual op %0h",
                     $time, rsp_bus_op);
            mismatches++;
         end else begin
            want = pending_actions.pop_front();
            report_field("bus_op", 32'(want.bus_op), 32'(rsp_bus_op));
            report_field("bus_address", 32'(want.bus_address), 32'(rsp_bus_address));
            report_field("oam_data", 32'(want.oam_data), 32'(rsp_oam_data));
            report_field("busy_res", 32'(want.busy_res), 32'(rsp_busy_res));
            report_field("cpu_proceed", 32'(want.cpu_proceed), 32'(rsp_cpu_proceed));
         end
      end
   end

   // End the run when no beat moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d actions outstanding", $time,
                  pending_actions.size());
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_extremes();
      test_drain_pause();
      test_random_runs();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_actions.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
